### rtl/core/obrf_pkg.sv
// Shared types and constants for the object box rotate filter.
package obrf_pkg;

   // Coordinates and sizes after scaling to the view. They are signed and wide enough
   // for every input bit pattern.
   typedef logic signed [13:0] coord_type;

   typedef logic [1:0]  rot_type;
   typedef logic [1:0]  anchor_type;
   typedef logic [43:0] window_type;
   typedef logic [21:0] size_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [43:0] csr_data_type;
   typedef logic [7:0]  count_type;

   localparam rot_type ROT_0   = 2'd0;
   localparam rot_type ROT_90  = 2'd1;
   localparam rot_type ROT_180 = 2'd2;
   localparam rot_type ROT_270 = 2'd3;

   localparam anchor_type ANCHOR_BOTTOM   = 2'd0;
   localparam anchor_type ANCHOR_MIDDLE   = 2'd1;
   localparam anchor_type ANCHOR_TOP_LEFT = 2'd2;

   localparam csr_index_type CSR_ROTATION    = 3'd0;
   localparam csr_index_type CSR_ANCHOR_MODE = 3'd1;
   localparam csr_index_type CSR_AREA_BOX    = 3'd2;
   localparam csr_index_type CSR_IGNORE_BOX  = 3'd3;
   localparam csr_index_type CSR_MIN_SIZE    = 3'd4;

   localparam logic MODE_BOX     = 1'b0;
   localparam logic MODE_EOF     = 1'b1;
   localparam logic KIND_OBJECT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam int FIELD_W = 11;

   // Area window resets to x1 = 0, y1 = 0, x2 = 1000, y2 = 1000.
   localparam window_type AREA_RESET   = {11'd1000, 11'd1000, 11'd0, 11'd0};
   localparam window_type IGNORE_RESET = '0;
   localparam size_type   MIN_RESET    = {11'd10, 11'd10};

   typedef struct packed {
      rot_type    rotation;
      anchor_type anchor_mode;
      window_type area_box;
      window_type ignore_box;
      size_type   min_size;
   } cfg_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
      coord_type ax;
      coord_type ay;
   } geom_type;

   typedef struct packed {
      logic      emit;
      logic      kind;
      count_type kept_total;
   } frame_status_type;

endpackage

### rtl/core/obrf_csr.sv
// Configuration register file written through the csr channel.
module obrf_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  obrf_pkg::csr_index_type csr_index,
   input  obrf_pkg::csr_data_type  csr_wdata,
   output obrf_pkg::cfg_type       cfg
);

   obrf_pkg::cfg_type cfg_ff;
   obrf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            obrf_pkg::CSR_ROTATION:    cfg_in.rotation    = csr_wdata[1:0];
            obrf_pkg::CSR_ANCHOR_MODE: cfg_in.anchor_mode = csr_wdata[1:0];
            obrf_pkg::CSR_AREA_BOX:    cfg_in.area_box    = csr_wdata[43:0];
            obrf_pkg::CSR_IGNORE_BOX:  cfg_in.ignore_box  = csr_wdata[43:0];
            obrf_pkg::CSR_MIN_SIZE:    cfg_in.min_size    = csr_wdata[21:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation    <= obrf_pkg::ROT_0;
         cfg_ff.anchor_mode <= obrf_pkg::ANCHOR_BOTTOM;
         cfg_ff.area_box    <= obrf_pkg::AREA_RESET;
         cfg_ff.ignore_box  <= obrf_pkg::IGNORE_RESET;
         cfg_ff.min_size    <= obrf_pkg::MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/obrf_map.sv
// Scales a scene box to view units, rotates it and picks its anchor point.
module obrf_map (
   input  obrf_pkg::cfg_type   cfg,
   input  logic signed [13:0]  box_left,
   input  logic signed [13:0]  box_top,
   input  logic        [13:0]  box_width,
   input  logic        [13:0]  box_height,
   output obrf_pkg::geom_type  geom
);

   localparam logic signed [15:0] SCENE_HALF = 16'sd4096;
   localparam logic signed [13:0] VIEW_SPAN  = 14'sd1000;

   // Multiply by 1000 and divide by 8192, truncating toward zero.
   function automatic obrf_pkg::coord_type scale(input logic signed [15:0] v);
      logic signed [25:0] prod;
      logic signed [25:0] biased;
      logic signed [25:0] quot;
      prod   = $signed({{10{v[15]}}, v}) * 26'sd1000;
      biased = prod + (prod[25] ? 26'sd8191 : 26'sd0);
      quot   = biased >>> 13;
      return quot[13:0];
   endfunction

   logic signed [15:0] mx, my, mw, mh;
   logic signed [15:0] x0, y0;
   obrf_pkg::coord_type sx, sy, sw, sh;
   obrf_pkg::coord_type x, y, w, h, ax, ay;

   always_comb begin
      mx = {{2{box_left[13]}}, box_left};
      my = {{2{box_top[13]}}, box_top};
      mw = {2'b00, box_width};
      mh = {2'b00, box_height};

      // A half turn mirrors both axes; the other views measure from the top edge.
      if (cfg.rotation == obrf_pkg::ROT_180) begin
         x0 = SCENE_HALF - mx - mw;
         y0 = SCENE_HALF + my;
      end else begin
         x0 = SCENE_HALF + mx;
         y0 = SCENE_HALF - my - mh;
      end

      sx = scale(x0);
      sy = scale(y0);
      sw = scale(mw);
      sh = scale(mh);

      unique case (cfg.rotation)
         obrf_pkg::ROT_90: begin
            w = sh;
            h = sw;
            x = VIEW_SPAN - sy - sh;
            y = sx;
         end
         obrf_pkg::ROT_270: begin
            w = sh;
            h = sw;
            x = sy;
            y = VIEW_SPAN - sx - sw;
         end
         default: begin
            w = sw;
            h = sh;
            x = sx;
            y = sy;
         end
      endcase

      // Sizes are never negative, so halving is a shift.
      unique case (cfg.anchor_mode)
         obrf_pkg::ANCHOR_BOTTOM: begin
            ax = x + (w >>> 1);
            ay = y + h;
         end
         obrf_pkg::ANCHOR_MIDDLE: begin
            ax = x + (w >>> 1);
            ay = y + (h >>> 1);
         end
         default: begin
            ax = x;
            ay = y;
         end
      endcase

      geom.x  = x;
      geom.y  = y;
      geom.w  = w;
      geom.h  = h;
      geom.ax = ax;
      geom.ay = ay;
   end

endmodule

### rtl/core/obrf_frame.sv
// Window and size filtering plus the per-frame kept counter.
module obrf_frame #(
   parameter int MAX_OBJECTS = 255
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       mode,
   input  obrf_pkg::cfg_type          cfg,
   input  obrf_pkg::geom_type         geom,
   output obrf_pkg::frame_status_type status
);

   localparam int LIMIT_INT = (MAX_OBJECTS < 255) ? MAX_OBJECTS : 255;
   localparam obrf_pkg::count_type KEPT_LIMIT = LIMIT_INT[7:0];

   // Zero-extends an 11-bit window field into the signed coordinate domain.
   function automatic obrf_pkg::coord_type fld(input logic [43:0] packed_box,
                                               input int idx);
      logic [10:0] raw;
      raw = packed_box[idx*obrf_pkg::FIELD_W +: obrf_pkg::FIELD_W];
      return $signed({3'b000, raw});
   endfunction

   obrf_pkg::count_type frame_kept_ff, frame_kept_in;
   logic                prev_empty_ff, prev_empty_in;

   logic outside, too_small, ignored, keep, empty;

   always_comb begin
      outside = (geom.ax < fld(cfg.area_box, 0)) || (geom.ax > fld(cfg.area_box, 2)) ||
                (geom.ay < fld(cfg.area_box, 1)) || (geom.ay > fld(cfg.area_box, 3));
      too_small = (geom.w < $signed({3'b000, cfg.min_size[10:0]})) ||
                  (geom.h < $signed({3'b000, cfg.min_size[21:11]}));
      ignored = (geom.ax > fld(cfg.ignore_box, 0)) && (geom.ax < fld(cfg.ignore_box, 2)) &&
                (geom.ay > fld(cfg.ignore_box, 1)) && (geom.ay < fld(cfg.ignore_box, 3));
      keep  = !outside && !too_small && !ignored;
      empty = (frame_kept_ff == '0);

      frame_kept_in     = frame_kept_ff;
      prev_empty_in     = prev_empty_ff;
      status.emit       = 1'b0;
      status.kind       = obrf_pkg::KIND_OBJECT;
      status.kept_total = '0;

      if (mode == obrf_pkg::MODE_EOF) begin
         status.kind   = obrf_pkg::KIND_SUMMARY;
         frame_kept_in = '0;
         // A second empty frame in a row gives no summary.
         if (!(prev_empty_ff && empty)) begin
            status.emit       = 1'b1;
            status.kept_total = frame_kept_ff;
            prev_empty_in     = empty;
         end
      end else if (keep) begin
         status.emit = 1'b1;
         if (frame_kept_ff < KEPT_LIMIT) begin
            frame_kept_in = frame_kept_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_kept_ff <= '0;
         prev_empty_ff <= 1'b0;
      end else if (step) begin
         frame_kept_ff <= frame_kept_in;
         prev_empty_ff <= prev_empty_in;
      end
   end

endmodule

### rtl/core/object_box_rotate_filter.sv
// Top level of the object box rotate filter: input register, mapping, filter and result register.

// Each req transaction carries either an object box in centered scene units (mode 0) or an
// end-of-frame marker (mode 1). A box is scaled to the 0 to 1000 view, rotated as the rotation
// register says, given an anchor point, and checked against the area window, the minimum size
// and the ignore window; a box that passes comes out as one rsp transaction of kind 0, a box
// that fails produces nothing. An end-of-frame marker produces a kind 1 transaction whose
// kept_total is the number of boxes kept since the previous marker, saturating at the smaller
// of MAX_OBJECTS and 255; it is withheld when this frame and the one before were both empty.
// The block accepts one transaction every clock cycle as long as rsp_ready keeps the result
// register draining. A result is offered on the rsp channel after its request has passed the
// input register: all the mapping and filtering is done by the combinational logic between it
// and the result register, and the result register loads once it is empty or being drained.
// When rsp_ready is low and the result register is full, the input register can still take one
// more transaction; once it holds one as well, req_ready drops in that same cycle and stays low
// until the result register drains. Configuration is written over the csr channel, which is
// always ready, and should only change while no transaction is in flight.
module object_box_rotate_filter #(
   parameter int MAX_OBJECTS = 255
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  obrf_pkg::csr_index_type csr_index,
   input  obrf_pkg::csr_data_type  csr_wdata,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [31:0]             req_object_id,
   input  logic signed [13:0]      req_box_left,
   input  logic signed [13:0]      req_box_top,
   input  logic [13:0]             req_box_width,
   input  logic [13:0]             req_box_height,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_kind,
   output logic [31:0]             rsp_out_id,
   output logic signed [11:0]      rsp_view_x,
   output logic signed [11:0]      rsp_view_y,
   output logic [9:0]              rsp_view_w,
   output logic [9:0]              rsp_view_h,
   output logic signed [11:0]      rsp_anchor_x,
   output logic signed [11:0]      rsp_anchor_y,
   output logic [7:0]              rsp_kept_total
);

   // Clamp a view coordinate to the signed 12-bit output range.
   function automatic logic signed [11:0] sat_s12(input obrf_pkg::coord_type v);
      logic signed [11:0] r;
      if (v > 14'sd2047) begin
         r = 12'sd2047;
      end else if (v < -14'sd2048) begin
         r = -12'sd2048;
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

   // Clamp a non-negative size to the 10-bit output range.
   function automatic logic [9:0] sat_u10(input obrf_pkg::coord_type v);
      logic [9:0] r;
      if (v > 14'sd1023) begin
         r = 10'd1023;
      end else if (v < 14'sd0) begin
         r = 10'd0;
      end else begin
         r = v[9:0];
      end
      return r;
   endfunction

   obrf_pkg::cfg_type          cfg;
   obrf_pkg::geom_type         geom;
   obrf_pkg::frame_status_type status;

   // Input register.
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_mode_ff;
   logic [31:0]         s1_id_ff;
   logic signed [13:0]  s1_left_ff, s1_top_ff;
   logic [13:0]         s1_width_ff, s1_height_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff;
   logic [31:0]         rsp_id_ff;
   logic signed [11:0]  rsp_x_ff, rsp_y_ff, rsp_ax_ff, rsp_ay_ff;
   logic [9:0]          rsp_w_ff, rsp_h_ff;
   logic [7:0]          rsp_total_ff;

   logic req_take, out_free, advance;

   assign csr_ready = 1'b1;

   obrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   obrf_map u_map (
      .cfg        (cfg),
      .box_left   (s1_left_ff),
      .box_top    (s1_top_ff),
      .box_width  (s1_width_ff),
      .box_height (s1_height_ff),
      .geom       (geom)
   );

   obrf_frame #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_frame (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .mode   (s1_mode_ff),
      .cfg    (cfg),
      .geom   (geom),
      .status (status)
   );

   // The held item moves on whenever the result register is empty or being drained;
   // frame state is updated in the same cycle, so the next item sees it at once.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = status.emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff   <= req_mode;
         s1_id_ff     <= req_object_id;
         s1_left_ff   <= req_box_left;
         s1_top_ff    <= req_box_top;
         s1_width_ff  <= req_box_width;
         s1_height_ff <= req_box_height;
      end
   end

   // Summaries carry only the count; kept objects carry everything but the count.
   always_ff @(posedge clock) begin
      if (advance && status.emit) begin
         rsp_kind_ff <= status.kind;
         if (status.kind == obrf_pkg::KIND_SUMMARY) begin
            rsp_id_ff    <= '0;
            rsp_x_ff     <= '0;
            rsp_y_ff     <= '0;
            rsp_w_ff     <= '0;
            rsp_h_ff     <= '0;
            rsp_ax_ff    <= '0;
            rsp_ay_ff    <= '0;
            rsp_total_ff <= status.kept_total;
         end else begin
            rsp_id_ff    <= s1_id_ff;
            rsp_x_ff     <= sat_s12(geom.x);
            rsp_y_ff     <= sat_s12(geom.y);
            rsp_w_ff     <= sat_u10(geom.w);
            rsp_h_ff     <= sat_u10(geom.h);
            rsp_ax_ff    <= sat_s12(geom.ax);
            rsp_ay_ff    <= sat_s12(geom.ay);
            rsp_total_ff <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_view_x     = rsp_x_ff;
   assign rsp_view_y     = rsp_y_ff;
   assign rsp_view_w     = rsp_w_ff;
   assign rsp_view_h     = rsp_h_ff;
   assign rsp_anchor_x   = rsp_ax_ff;
   assign rsp_anchor_y   = rsp_ay_ff;
   assign rsp_kept_total = rsp_total_ff;

endmodule
